[hw/rtl/jfs_pkg.sv]
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared types and constants for the five-point Jacobi stencil sweep.
// ----------------------------------------------------------------------------
package jfs_pkg;

  localparam int DATA_WIDTH     = 32;    // Q16.16 grid values
  localparam int COL_W          = 10;    // interior_cols / out_col
  localparam int ROW_W          = 16;    // interior_rows / out_row
  localparam int ROWCNT_W       = ROW_W + 1;
  localparam int HSQ_W          = 31;    // h_sq, unsigned Q0.32 value held in 31 bits (MSB zero)
  localparam int HSQ_FRAC       = 32;
  localparam int DEF_MAX_COLS   = 1024;
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  localparam logic [COL_W-1:0] COLS_RST = COL_W'(1022);
  localparam logic [ROW_W-1:0] ROWS_RST = ROW_W'(1);
  localparam logic [HSQ_W-1:0] HSQ_RST  = '0;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_HSQ  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] u_value;
    logic signed [DATA_WIDTH-1:0] f_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] new_value;
    logic        [ROW_W-1:0]      out_row;
    logic        [COL_W-1:0]      out_col;
    logic                         last_out;
  } out_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    logic [HSQ_W-1:0] h_sq;
  } cfg_t;

  // one line-buffer column: u two rows up, u one row up, f one row up
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] prev2_u;
    logic signed [DATA_WIDTH-1:0] prev_u;
    logic signed [DATA_WIDTH-1:0] prev_f;
  } line_entry_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_out;
  } meta_t;

  // results still in the datapath, for the output queue credit
  typedef struct packed {
    logic s1_emit;
    logic s2_emit;
  } dp_status_t;

endpackage

[hw/rtl/jacobi_five_point_stencil_sweep.sv]
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil_sweep
// One Jacobi update of a padded 2D Poisson grid streamed in raster order.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | carries
//   --------+--------------------------------+-------------------------------
//   in      | in_valid / in_ready / in_data  | u_value, f_value per cell
//   out     | out_valid / out_ready/out_data | new_value, out_row, out_col,
//           |                                | last_out per interior cell
//   cfg     | psel penable pwrite paddr      | interior_cols (0x0),
//           | pwdata prdata pready           | interior_rows (0x4), h_sq (0x8)
//
// Takes one cell per cycle while in_ready is high. An accepted cell passes
// the line-buffer read and the registered sum and multiply, then is
// subtracted and saturated into the result queue that drives out_valid.
// The single line-buffer RAM is read and written once per cell, which sets
// the one-cell-per-cycle rate.
// in_ready depends only on registered state: it drops while the 4-entry
// result queue plus the results still in flight would fill it, so a stalled
// out_ready holds the input back via registered state, never combinationally.
// Synchronous reset clears counters, valid flags and config registers; the
// data registers and line buffer are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil_sweep #(
  parameter int MAX_COLS = jfs_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  jfs_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output jfs_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jfs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jfs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import jfs_pkg::*;

  // column counter doubles as the line-buffer address
  localparam int ADDR_W   = $clog2(MAX_COLS);
  localparam int CNT_W    = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int ClampInt = (MAX_COLS - 2 > (1 << COL_W) - 1) ? (1 << COL_W) - 1
                                                            : MAX_COLS - 2;
  localparam logic [COL_W-1:0]    COL_CLAMP = COL_W'(ClampInt);
  localparam logic [ADDR_W-1:0]   COL_TWO   = ADDR_W'(2);
  localparam logic [ROWCNT_W-1:0] ROW_TWO   = ROWCNT_W'(2);

  cfg_t                cfg;
  logic [COL_W-1:0]    cols_eff;
  logic [ROW_W-1:0]    rows_eff;
  logic [ADDR_W-1:0]   last_col;
  logic [ROWCNT_W-1:0] last_row;

  logic [ADDR_W-1:0]   col_r;
  logic [ADDR_W-1:0]   col_nxt;
  logic [ROWCNT_W-1:0] row_r;
  logic [ROWCNT_W-1:0] row_nxt;
  logic [ADDR_W-1:0]   cw;
  logic [ROWCNT_W-1:0] rw;

  logic                acc;
  logic                acc_emit;
  meta_t               acc_meta;

  line_entry_t         rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  line_entry_t         wr_data;

  logic                push;
  out_item_t           push_item;
  dp_status_t          status;
  logic [CNT_W-1:0]    fifo_cnt;
  logic [CNT_W-1:0]    inflight;

  jfs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective grid size: zero counts act as one, columns clamp to the
  // line-buffer depth less the two padding cells.
  always_comb begin
    cols_eff = cfg.cols;
    if (cols_eff == '0) begin
      cols_eff = COL_W'(1);
    end
    if (cols_eff > COL_CLAMP) begin
      cols_eff = COL_CLAMP;
    end
    rows_eff = (cfg.rows == '0) ? ROW_W'(1) : cfg.rows;
  end

  assign last_col = ADDR_W'(ADDR_W'(cols_eff) + 1'b1);
  assign last_row = ROWCNT_W'(ROWCNT_W'(rows_eff) + 1'b1);

  // Position of the incoming cell. Counters left beyond a new (smaller)
  // bound after a size change wrap to the next row or grid first.
  always_comb begin
    cw = col_r;
    rw = row_r;
    if (cw > last_col) begin
      cw = '0;
      rw = ROWCNT_W'(rw + 1'b1);
    end
    if (rw > last_row) begin
      rw = '0;
    end
    if (cw >= last_col) begin
      col_nxt = '0;
      row_nxt = (rw >= last_row) ? '0 : ROWCNT_W'(rw + 1'b1);
    end else begin
      col_nxt = ADDR_W'(cw + 1'b1);
      row_nxt = rw;
    end
  end

  // Output for interior cell (r-1, c-1) fires on the south-east cell (r, c).
  assign acc_emit          = (rw >= ROW_TWO) && (cw >= COL_TWO);
  assign acc_meta.out_row  = ROW_W'(rw - 1'b1);
  assign acc_meta.out_col  = COL_W'(cw - 1'b1);
  assign acc_meta.last_out = (rw == last_row) && (cw == last_col);

  // Credit check: queue entries plus results still in the datapath, plus
  // this request, must fit in the queue.
  assign inflight = CNT_W'(fifo_cnt + CNT_W'(status.s1_emit) + CNT_W'(status.s2_emit));
  assign in_ready = (inflight < CNT_W'(OUT_FIFO_DEPTH));
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Read of column c is issued with the request; write-back of the same
  // column follows in the next cycle. Consecutive requests always hit
  // different columns, so a read never races the pending write.
  jfs_line_mem #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (cw),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  jfs_stencil_dp #(
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_data),
    .acc_addr  (cw),
    .acc_emit  (acc_emit),
    .acc_meta  (acc_meta),
    .h_sq      (cfg.h_sq),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_item (push_item),
    .status    (status)
  );

  jfs_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_data),
    .count     (fifo_cnt)
  );

`ifndef SYNTHESIS
  // credit scheme must keep the result queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (fifo_cnt == CNT_W'(OUT_FIFO_DEPTH))) |-> out_ready)
    else $error("result queue overflow");

  // line-buffer write-back never collides with a fresh read of its column
  a_mem_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && acc) |-> (wr_addr != cw))
    else $error("line buffer read/write to same column");

  // an emitting request reaches the result queue after the stage-1 and stage-2 registers
  a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && acc_emit) |-> ##2 push)
    else $error("result lost in datapath");
`endif

endmodule

[hw/rtl/jfs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// jfs_cfg_regs
// APB-style register file: grid size and h_sq.
// ----------------------------------------------------------------------------
module jfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jfs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jfs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output jfs_pkg::cfg_t                  cfg
);
  import jfs_pkg::*;

  reg_idx_t         idx;
  logic             wr;
  logic [COL_W-1:0] cols_r;
  logic [ROW_W-1:0] rows_r;
  logic [HSQ_W-1:0] h_sq_r;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
      h_sq_r <= HSQ_RST;
    end else if (wr) begin
      case (idx)
        REG_COLS: cols_r <= pwdata[COL_W-1:0];
        REG_ROWS: rows_r <= pwdata[ROW_W-1:0];
        REG_HSQ:  h_sq_r <= pwdata[HSQ_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COLS: prdata = CFG_DATA_W'(cols_r);
      REG_ROWS: prdata = CFG_DATA_W'(rows_r);
      REG_HSQ:  prdata = CFG_DATA_W'(h_sq_r);
      default:  prdata = '0;
    endcase
  end

  assign cfg.cols = cols_r;
  assign cfg.rows = rows_r;
  assign cfg.h_sq = h_sq_r;

endmodule

[hw/rtl/jfs_line_mem.sv]
// ----------------------------------------------------------------------------
// jfs_line_mem
// Line-buffer RAM, one column per entry, registered read.
// ----------------------------------------------------------------------------
module jfs_line_mem #(
  parameter int DEPTH  = jfs_pkg::DEF_MAX_COLS,
  parameter int ADDR_W = $clog2(jfs_pkg::DEF_MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output jfs_pkg::line_entry_t  rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  jfs_pkg::line_entry_t  wr_data
);
  import jfs_pkg::*;

  line_entry_t line_mem_r [DEPTH];
  line_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/jfs_stencil_dp.sv]
// ----------------------------------------------------------------------------
// jfs_stencil_dp
// Window registers, line-buffer write-back and the stencil arithmetic.
// ----------------------------------------------------------------------------
module jfs_stencil_dp #(
  parameter int ADDR_W = $clog2(jfs_pkg::DEF_MAX_COLS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  jfs_pkg::in_item_t           in_item,
  input  logic [ADDR_W-1:0]           acc_addr,
  input  logic                        acc_emit,
  input  jfs_pkg::meta_t              acc_meta,
  input  logic [jfs_pkg::HSQ_W-1:0]   h_sq,
  input  jfs_pkg::line_entry_t        rd_data,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output jfs_pkg::line_entry_t        wr_data,
  output logic                        push,
  output jfs_pkg::out_item_t          push_item,
  output jfs_pkg::dp_status_t         status
);
  import jfs_pkg::*;

  localparam int SUM_W  = DATA_WIDTH + 2;
  localparam int PROD_W = HSQ_W + 1 + DATA_WIDTH;
  localparam int DIFF_W = SUM_W + HSQ_FRAC + 1;
  localparam int Q_W    = DIFF_W - HSQ_FRAC - 2;
  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // stage 1: item waits for its line-buffer read
  logic                         s1_valid_r;
  logic                         s1_emit_r;
  logic signed [DATA_WIDTH-1:0] s1_u_r;
  logic signed [DATA_WIDTH-1:0] s1_f_r;
  logic [ADDR_W-1:0]            s1_addr_r;
  meta_t                        s1_meta_r;

  // window
  logic signed [DATA_WIDTH-1:0] west_r;
  logic signed [DATA_WIDTH-1:0] mid_r;
  logic signed [DATA_WIDTH-1:0] north_r;
  logic signed [DATA_WIDTH-1:0] src_r;
  logic signed [DATA_WIDTH-1:0] south_r;

  // stage 2: neighbor sum and h_sq * source
  logic                         s2_emit_r;
  logic signed [SUM_W-1:0]      s2_sum_r;
  logic signed [PROD_W-1:0]     s2_prod_r;
  meta_t                        s2_meta_r;

  logic signed [DATA_WIDTH-1:0] east;
  logic signed [SUM_W-1:0]      sum_nxt;
  logic signed [PROD_W-1:0]     hsq_ext;
  logic signed [PROD_W-1:0]     src_ext;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [Q_W-1:0]        q;
  logic [Q_W-DATA_WIDTH:0]      q_hi;
  logic signed [DATA_WIDTH-1:0] result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      s2_emit_r  <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      s1_emit_r  <= acc && acc_emit;
      s2_emit_r  <= s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_u_r    <= in_item.u_value;
      s1_f_r    <= in_item.f_value;
      s1_addr_r <= acc_addr;
      s1_meta_r <= acc_meta;
    end
    if (s1_valid_r) begin
      west_r  <= mid_r;
      mid_r   <= east;
      north_r <= rd_data.prev2_u;
      src_r   <= rd_data.prev_f;
      south_r <= s1_u_r;
    end
    s2_sum_r  <= sum_nxt;
    s2_prod_r <= prod_nxt;
    s2_meta_r <= s1_meta_r;
  end

  // east neighbor comes straight from the line buffer; the rest from the window
  assign east     = rd_data.prev_u;
  assign sum_nxt  = SUM_W'(north_r) + SUM_W'(south_r) + SUM_W'(east) + SUM_W'(west_r);
  assign hsq_ext  = PROD_W'($signed({1'b0, h_sq}));
  assign src_ext  = PROD_W'(src_r);
  assign prod_nxt = hsq_ext * src_ext;

  // column shifts down a row: u above moves to two above
  assign wr_en           = s1_valid_r;
  assign wr_addr         = s1_addr_r;
  assign wr_data.prev2_u = east;
  assign wr_data.prev_u  = s1_u_r;
  assign wr_data.prev_f  = s1_f_r;

  // floor((S * 2^32 - P) / 2^34), then saturate
  assign diff = {s2_sum_r[SUM_W-1], s2_sum_r, {HSQ_FRAC{1'b0}}} - DIFF_W'(s2_prod_r);
  assign q    = diff[DIFF_W-1:HSQ_FRAC+2];
  assign q_hi = q[Q_W-1:DATA_WIDTH-1];

  always_comb begin
    if ((q_hi == '0) || (q_hi == '1)) begin
      result = q[DATA_WIDTH-1:0];
    end else if (q[Q_W-1]) begin
      result = SAT_MIN;
    end else begin
      result = SAT_MAX;
    end
  end

  assign push               = s2_emit_r;
  assign push_item.new_value = result;
  assign push_item.out_row   = s2_meta_r.out_row;
  assign push_item.out_col   = s2_meta_r.out_col;
  assign push_item.last_out  = s2_meta_r.last_out;

  assign status.s1_emit = s1_emit_r;
  assign status.s2_emit = s2_emit_r;

endmodule

[hw/rtl/jfs_out_fifo.sv]
// ----------------------------------------------------------------------------
// jfs_out_fifo
// Small shifting result queue; head is always slot 0.
// ----------------------------------------------------------------------------
module jfs_out_fifo #(
  parameter int DEPTH = jfs_pkg::OUT_FIFO_DEPTH,
  parameter int CNT_W = $clog2(jfs_pkg::OUT_FIFO_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jfs_pkg::out_item_t push_item,
  input  logic               out_ready,
  output logic               out_valid,
  output jfs_pkg::out_item_t out_item,
  output logic [CNT_W-1:0]   count
);
  import jfs_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  out_item_t        q_r   [DEPTH];
  out_item_t        q_nxt [DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] wr_pos;
  logic             pop;

  assign pop       = out_ready && (cnt_r != '0);
  assign out_valid = (cnt_r != '0);
  assign out_item  = q_r[0];
  assign count     = cnt_r;
  assign wr_pos    = pop ? CNT_W'(cnt_r - 1'b1) : cnt_r;
  assign cnt_nxt   = CNT_W'(cnt_r + CNT_W'(push) - CNT_W'(pop));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    if (push) begin
      q_nxt[wr_pos[IDX_W-1:0]] = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule
